// ----- rtl/arwm_pkg.sv -----
package arwm_pkg;

    // Field and register widths.
    localparam int SAMPLE_W = 10;
    localparam int RMS_W    = 19;
    localparam int CHAN_W   = 2;
    localparam int SKIP_W   = 12;
    localparam int ROW_W    = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    // Datapath widths.
    localparam int DIFF_W   = 10;   // |sample - 512| is at most 512
    localparam int SQ_W     = 20;   // square of the offset
    localparam int SUM_W    = 31;   // running sum of squares
    localparam int MUL_A_W  = 31;
    localparam int MUL_B_W  = 20;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int RAD_W    = 38;   // sum * 1e6 / rows stays below 2**38
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int STEP_W   = 6;

    localparam int DIV_STEPS  = PROD_W;
    localparam int ROOT_STEPS = ROOT_W;

    // Constants of the measurement.
    localparam logic [SAMPLE_W-1:0] MIDSCALE   = SAMPLE_W'(512);
    localparam logic [MUL_B_W-1:0]  SCALE_SQ   = MUL_B_W'(1000000);
    localparam logic [ROW_W-1:0]    MAX_WINDOW = ROW_W'(4096);
    localparam int                  CHANNELS   = 4;

    // Reset values of the configuration registers.
    localparam logic [CHAN_W-1:0] CHAN_RESET = '0;
    localparam logic [SKIP_W-1:0] SKIP_RESET = '0;
    localparam logic [ROW_W-1:0]  WIN_RESET  = ROW_W'(1000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd2;

endpackage

// ----- rtl/arwm_if.sv -----
interface arwm_row_if import arwm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch3;

    modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                    input ready);
    modport sink   (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                    output ready);
endinterface

interface arwm_level_if import arwm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RMS_W-1:0] rms_milli;

    modport source (output valid, rms_milli, input ready);
    modport sink   (input valid, rms_milli, output ready);
endinterface

// ----- rtl/arwm_mul.sv -----
module arwm_mul import arwm_pkg::*;
(
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [PROD_W-1:0]  p
);

    // Unsigned multiplier shared by the squaring and the scaling step.
    assign p = PROD_W'(a) * PROD_W'(b);

endmodule

// ----- rtl/arwm_cmp_sub.sv -----
module arwm_cmp_sub import arwm_pkg::*;
(
    input  logic [REM_W-1:0] a,
    input  logic [REM_W-1:0] b,
    output logic [REM_W-1:0] diff,
    output logic             ge
);

    logic [REM_W:0] wide;

    // One trial subtraction: the borrow out tells whether a >= b.
    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[REM_W];
    assign diff = wide[REM_W-1:0];

endmodule

// ----- rtl/adc_window_rms_meter.sv -----
// A skipped row is taken while the block stays idle; a row inside the window
// passes through the accumulate state, and the last row of a window then runs
// the scale, divide, root and done states, the steps of the divide and root
// on the shared subtract unit. One row per cycle while skipping; in a window
// the next row waits out the accumulate state. Reset (rst_n low, asynchronous)
// clears sum, row count, phase and output valid flag, loads register defaults.
module adc_window_rms_meter import arwm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    arwm_row_if.sink             row,
    arwm_level_if.source         level
);

    // The sequencer walks one request through these states. Rows outside the
    // window and rows that do not close it return to idle quickly; the row
    // that closes a window runs the scale, divide and root phases.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ACCUM  = 6'b000010,
        ST_SCALE  = 6'b000100,
        ST_DIVIDE = 6'b001000,
        ST_ROOT   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;

    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic [ROW_W-1:0]    win_reg, win_next;

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [ROW_W-1:0]    row_cnt_reg, row_cnt_next;
    logic                in_window_reg, in_window_next;

    logic [SQ_W-1:0]     prod_reg, prod_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic                out_valid_reg, out_valid_next;
    logic [RMS_W-1:0]    out_data_reg, out_data_next;

    logic [SAMPLE_W-1:0] sample_sel;
    logic [DIFF_W-1:0]   offset;
    logic [ROW_W-1:0]    eff_win;
    logic [ROW_W-1:0]    row_cnt_inc;
    logic                row_accept;
    logic                level_accept;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;

    logic [REM_W-1:0]    cs_a;
    logic [REM_W-1:0]    cs_b;
    logic [REM_W-1:0]    cs_diff;
    logic                cs_ge;

    assign row.ready    = (state_reg == ST_IDLE);
    assign row_accept   = row.valid && row.ready;
    assign level.valid  = out_valid_reg;
    assign level.rms_milli = out_data_reg;
    assign level_accept = level.valid && level.ready;

    // Channel select is two bits wide, so it already wraps over the four
    // channels of a row.
    always_comb
    begin
        case (chan_reg)
            2'd0:    sample_sel = row.sample_ch0;
            2'd1:    sample_sel = row.sample_ch1;
            2'd2:    sample_sel = row.sample_ch2;
            default: sample_sel = row.sample_ch3;
        endcase
    end

    // Distance from midscale; 512 itself still fits in ten bits.
    assign offset = (sample_sel >= MIDSCALE) ? DIFF_W'(sample_sel - MIDSCALE)
                                             : DIFF_W'(MIDSCALE - sample_sel);

    // A window length of zero counts as one row; lengths above the maximum
    // are clamped.
    always_comb
    begin
        if (win_reg == '0)
        begin
            eff_win = ROW_W'(1);
        end
        else if (win_reg > MAX_WINDOW)
        begin
            eff_win = MAX_WINDOW;
        end
        else
        begin
            eff_win = win_reg;
        end
    end

    assign row_cnt_inc = row_cnt_reg + ROW_W'(1);

    // The one multiplier squares the offset on a row request and scales the
    // sum by one million at the end of a window.
    always_comb
    begin
        if (state_reg == ST_SCALE)
        begin
            mul_a = sum_reg;
            mul_b = SCALE_SQ;
        end
        else
        begin
            mul_a = MUL_A_W'(offset);
            mul_b = MUL_B_W'(offset);
        end
    end

    arwm_mul u_mul
    (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    // The compare-subtract unit serves both long phases. During the divide
    // it takes the partial remainder with the next dividend bit against the
    // row count. During the root it takes the remainder with the next two
    // radicand bits against the trial value {root, 01}.
    always_comb
    begin
        if (state_reg == ST_ROOT)
        begin
            cs_a = {rem_reg[REM_W-3:0], acc_reg[RAD_W-1 -: 2]};
            cs_b = {root_reg, 2'b01};
        end
        else
        begin
            cs_a = {rem_reg[REM_W-2:0], acc_reg[PROD_W-1]};
            cs_b = REM_W'(row_cnt_reg);
        end
    end

    arwm_cmp_sub u_cmp_sub
    (
        .a    (cs_a),
        .b    (cs_b),
        .diff (cs_diff),
        .ge   (cs_ge)
    );

    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        skip_next      = skip_reg;
        win_next       = win_reg;
        sum_next       = sum_reg;
        row_cnt_next   = row_cnt_reg;
        in_window_next = in_window_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // The user must write registers only while the block is idle; the block itself does not enforce this.
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_SELECT: chan_next = cfg_data[CHAN_W-1:0];
                CFG_SKIP_ROWS:      skip_next = cfg_data[SKIP_W-1:0];
                CFG_WINDOW_LENGTH:  win_next  = cfg_data[ROW_W-1:0];
                default:            ;
            endcase
        end

        if (level_accept)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (row_accept)
                begin
                    if (!in_window_reg && (row_cnt_reg < ROW_W'(skip_reg)))
                    begin
                        // Row discarded before the window opens.
                        row_cnt_next = row_cnt_inc;
                    end
                    else
                    begin
                        if (!in_window_reg)
                        begin
                            in_window_next = 1'b1;
                            row_cnt_next   = '0;
                            sum_next       = '0;
                        end
                        prod_next  = mul_p[SQ_W-1:0];
                        state_next = ST_ACCUM;
                    end
                end
            end

            ST_ACCUM:
            begin
                sum_next     = sum_reg + SUM_W'(prod_reg);
                row_cnt_next = row_cnt_inc;
                if (row_cnt_inc >= eff_win)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCALE:
            begin
                acc_next   = mul_p;
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIVIDE;
            end

            ST_DIVIDE:
            begin
                // Restoring division, one quotient bit per cycle shifted into
                // the low end of the accumulator.
                acc_next  = {acc_reg[PROD_W-2:0], cs_ge};
                rem_next  = cs_ge ? cs_diff : cs_a;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
            end

            ST_ROOT:
            begin
                // Digit-by-digit square root, one result bit per cycle.
                acc_next  = {acc_reg[PROD_W-3:0], 2'b00};
                rem_next  = cs_ge ? cs_diff : cs_a;
                root_next = {root_reg[ROOT_W-2:0], cs_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hand the result over once the output register is free,
                // then go back to skipping.
                if (!out_valid_reg || level.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = RMS_W'(root_reg);
                    sum_next       = '0;
                    row_cnt_next   = '0;
                    in_window_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= CHAN_RESET;
            skip_reg      <= SKIP_RESET;
            win_reg       <= WIN_RESET;
            sum_reg       <= '0;
            row_cnt_reg   <= '0;
            in_window_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            skip_reg      <= skip_next;
            win_reg       <= win_next;
            sum_reg       <= sum_next;
            row_cnt_reg   <= row_cnt_next;
            in_window_reg <= in_window_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/arwm_checker.sv -----
module arwm_checker import arwm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             row_ready,
    input logic             level_valid,
    input logic             level_ready,
    input logic [RMS_W-1:0] rms_milli
);

    // A pending result stays offered until it is taken.
    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid && !level_ready |=> level_valid)
        else $error("result request dropped before it was taken");

    // A stalled result keeps its value.
    a_level_stable: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid && !level_ready |=> $stable(rms_milli))
        else $error("result changed while stalled");

    // The level never exceeds full scale of 512.000.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid |-> (rms_milli <= RMS_W'(512000)))
        else $error("result above full scale");

    // A new result comes only out of the window-end computation, during
    // which no row is taken.
    a_level_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(level_valid) |-> $past(!row_ready))
        else $error("result appeared without the window-end computation");

endmodule

bind adc_window_rms_meter arwm_checker u_arwm_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .row_ready   (row.ready),
    .level_valid (level.valid),
    .level_ready (level.ready),
    .rms_milli   (level.rms_milli)
);

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import arwm_pkg::*;

    // The watchdog ends the run after this many cycles in which neither a row
    // request nor a level request is accepted. The slowest legal quiet stretch
    // is the settling pause before a register write plus one window's result
    // latency, both far below this.
    localparam int WATCHDOG_LIMIT = 4000;

    // Quiet cycles allowed after the last expected level before the block is
    // treated as idle. The last row of a window still runs the scale, divide
    // and root phases before its result, and rows that are skipped produce nothing at all.
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ch3;
        logic [SAMPLE_W-1:0] ch2;
        logic [SAMPLE_W-1:0] ch1;
        logic [SAMPLE_W-1:0] ch0;
    } adc_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    arwm_row_if   row_bus ();
    arwm_level_if level_bus ();

    adc_window_rms_meter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row       (row_bus),
        .level     (level_bus)
    );

    always #4 clk = ~clk;

    // Shadow copy of the meter: its registers and its accumulation state.
    logic [CHAN_W-1:0] meter_channel;
    logic [SKIP_W-1:0] meter_skip;
    logic [ROW_W-1:0]  meter_window;
    logic [SUM_W-1:0]  meter_sum;
    logic [ROW_W-1:0]  meter_rows;
    bit                meter_in_window;

    // Levels that the shadow copy says the block still owes us, oldest first.
    logic [RMS_W-1:0]  level_expect_q [$];
    logic [RMS_W-1:0]  expected_level;

    int mismatches = 0;
    int idle_cycles = 0;
    int levels_predicted = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    // Floor of the square root, built one result bit at a time from the top.
    // The radicand stays below 2**38, so the root fits in ROOT_W + 1 bits.
    function automatic longint unsigned floor_root(longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = ROOT_W; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    function automatic void reset_meter_model();
        meter_channel   = CHAN_RESET;
        meter_skip      = SKIP_RESET;
        meter_window    = WIN_RESET;
        meter_sum       = '0;
        meter_rows      = '0;
        meter_in_window = 1'b0;
    endfunction

    // Advances the shadow copy by one accepted row request and queues the
    // level that the row completes, if any.
    function automatic void predict_level(adc_row_t r);
        logic [SAMPLE_W-1:0] sample;
        longint unsigned     offset;
        longint unsigned     radicand;
        int unsigned         limit;
        if (!meter_in_window)
        begin
            // Skipping phase: the row is dropped until the skip count is met,
            // and the row that meets it already opens the window.
            if (meter_rows < meter_skip)
            begin
                meter_rows = meter_rows + 1'b1;
                return;
            end
            meter_in_window = 1'b1;
            meter_rows      = '0;
            meter_sum       = '0;
        end
        case (meter_channel)
            2'd0: sample = r.ch0;
            2'd1: sample = r.ch1;
            2'd2: sample = r.ch2;
            default: sample = r.ch3;
        endcase
        offset     = (sample >= MIDSCALE) ? sample - MIDSCALE : MIDSCALE - sample;
        meter_sum  = meter_sum + SUM_W'(offset * offset);
        meter_rows = meter_rows + 1'b1;
        // A zero window length acts as one row, and lengths past the maximum
        // are held at the maximum.
        if (meter_window == '0)
            limit = 1;
        else if (meter_window > MAX_WINDOW)
            limit = MAX_WINDOW;
        else
            limit = meter_window;
        if (meter_rows >= limit)
        begin
            // The divisor is the number of rows really summed, which differs
            // from the window length when the length was cut mid-window.
            radicand = (64'(meter_sum) * 64'(SCALE_SQ)) / 64'(meter_rows);
            level_expect_q.push_back(RMS_W'(floor_root(radicand)));
            levels_predicted++;
            meter_sum       = '0;
            meter_rows      = '0;
            meter_in_window = 1'b0;
        end
    endfunction

    // Samples lean toward the corners of the range and the midscale point.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(511, 513));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic adc_row_t random_row();
        adc_row_t r;
        r.ch0 = random_sample();
        r.ch1 = random_sample();
        r.ch2 = random_sample();
        r.ch3 = random_sample();
        return r;
    endfunction

    // Channel select word with random junk above the two select bits, which
    // the block has to mask off.
    function automatic logic [CFG_W-1:0] channel_word(int ch);
        logic [CFG_W-1:0] w;
        w = CFG_W'($urandom);
        w[CHAN_W-1:0] = CHAN_W'(ch);
        return w;
    endfunction

    // Sends one row request. Inputs move only at the falling edge, so the
    // block sees stable values at every rising edge. Valid stays high after
    // acceptance until the next falling edge decides what comes next, which
    // keeps back-to-back requests free of a low glitch.
    task automatic send_row(input adc_row_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            row_bus.valid = 1'b0;
            @(negedge clk);
        end
        row_bus.valid      = 1'b1;
        row_bus.sample_ch0 = r.ch0;
        row_bus.sample_ch1 = r.ch1;
        row_bus.sample_ch2 = r.ch2;
        row_bus.sample_ch3 = r.ch3;
        @(posedge clk);
        while (!row_bus.ready)
            @(posedge clk);
        predict_level(r);
    endtask

    // Drops valid and waits until every owed level has arrived, then lets the
    // block finish any trailing work. Returns at a falling edge.
    task automatic settle();
        @(negedge clk);
        row_bus.valid = 1'b0;
        while (level_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        case (idx)
            CFG_CHANNEL_SELECT: meter_channel = data[CHAN_W-1:0];
            CFG_SKIP_ROWS:      meter_skip    = data[SKIP_W-1:0];
            CFG_WINDOW_LENGTH:  meter_window  = data[ROW_W-1:0];
            default: ;
        endcase
    endtask

    // All three registers are rewritten, and only once the block is quiet.
    task automatic configure(input logic [CFG_W-1:0] chan_word,
                             input logic [CFG_W-1:0] skip_word,
                             input logic [CFG_W-1:0] win_word);
        settle();
        write_reg(CFG_CHANNEL_SELECT, chan_word);
        write_reg(CFG_SKIP_ROWS, skip_word);
        write_reg(CFG_WINDOW_LENGTH, win_word);
        cfg_we = 1'b0;
    endtask

    // Every channel is measured with one-row windows, so each row yields a
    // level. The rows put the sample corners, midscale and a neighbor of it on
    // each channel. The window length is written as zero, which must act as
    // one row, and the skip count is zero, so the very first row is summed.
    task automatic test_field_extremes();
        adc_row_t patterns [4];
        patterns[0] = '{ch3: 10'd511, ch2: 10'd512, ch1: 10'd1023, ch0: 10'd0};
        patterns[1] = '{ch3: 10'd512, ch2: 10'd511, ch1: 10'd0, ch0: 10'd1023};
        patterns[2] = '{ch3: 10'd1023, ch2: 10'd0, ch1: 10'd513, ch0: 10'd512};
        patterns[3] = '{ch3: 10'd0, ch2: 10'd1023, ch1: 10'd512, ch0: 10'd511};
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            configure(channel_word(ch), '0, '0);
            foreach (patterns[i])
                send_row(patterns[i]);
        end
    endtask

    // Two skipped rows followed by a three-row window of extreme samples.
    task automatic test_skip_and_window();
        configure(channel_word(2), CFG_W'(2), CFG_W'(3));
        send_row(random_row());
        send_row(random_row());
        send_row('{ch3: '1, ch2: '0, ch1: '1, ch0: '0});
        send_row('{ch3: '0, ch2: '1, ch1: '0, ch0: '1});
        send_row('{ch3: '1, ch2: '0, ch1: '1, ch0: '0});
    endtask

    // Registers rewritten while a phase is under way. A window that has
    // already run past the new length must end on the next row, divided by
    // the rows it really holds. A skip count lowered below the rows already
    // skipped must open the window on the next row.
    task automatic test_register_change();
        configure(channel_word(1), '0, CFG_W'(10));
        repeat (6) send_row(random_row());
        configure(channel_word(1), '0, CFG_W'(3));
        send_row(random_row());
        configure(channel_word(3), CFG_W'(8), CFG_W'(4));
        repeat (5) send_row(random_row());
        configure(channel_word(3), CFG_W'(2), CFG_W'(4));
        repeat (4) send_row(random_row());
    endtask

    // The largest skip count, then a window length past the maximum, which is
    // held at the maximum. Both phases are cut short by lowering the register
    // part way through, so the window ends on the next row and is divided by
    // the rows it really holds. The measured channel sits at or next to the
    // farthest sample on every row, so the level is close to full scale.
    task automatic test_register_extremes();
        adc_row_t r;
        send_idle_pct = 22;
        stall_pct     = 22;
        configure(channel_word(3), '1, '1);
        repeat (30) send_row(random_row());
        configure(channel_word(0), '0, '1);
        repeat (50)
        begin
            r     = random_row();
            r.ch0 = '0;
            send_row(r);
        end
        configure(channel_word(0), '0, '0);
        r     = random_row();
        r.ch0 = '1;
        send_row(r);
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // One idling phase of random traffic: short windows and short skips, with
    // the registers rewritten at random points, so windows are often cut
    // short or stretched mid-way.
    task automatic random_phase(input int sender_pct, input int receiver_pct, input int quota);
        int               rows_sent;
        int               levels_at_start;
        logic [CFG_W-1:0] skip_word;
        logic [CFG_W-1:0] win_word;
        send_idle_pct   = sender_pct;
        stall_pct       = receiver_pct;
        rows_sent       = 0;
        levels_at_start = levels_predicted;
        while (rows_sent < quota || levels_predicted - levels_at_start < 12)
        begin
            skip_word = CFG_W'($urandom_range(0, ($urandom_range(7) == 0) ? 40 : 6));
            skip_word[SKIP_W] = 1'($urandom);
            case ($urandom_range(9))
                0: win_word = '0;
                1: win_word = CFG_W'($urandom_range(13, 60));
                default: win_word = CFG_W'($urandom_range(1, 12));
            endcase
            configure(channel_word($urandom_range(CHANNELS - 1)), skip_word, win_word);
            repeat ($urandom_range(4, 40))
            begin
                send_row(random_row());
                rows_sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(0, 0, 130);
        random_phase(81, 0, 130);
        random_phase(0, 81, 130);
        random_phase(22, 22, 130);
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // The level receiver decides at each falling edge whether to stall.
    always @(negedge clk)
        level_bus.ready = ($urandom_range(99) >= stall_pct);

    // Every accepted level request is checked against the oldest owed level.
    always @(posedge clk)
    begin
        if (rst_n && level_bus.valid && level_bus.ready)
        begin
            if (level_expect_q.size() == 0)
            begin
                $error("rms_milli: expected no result, actual %0d", level_bus.rms_milli);
                mismatches++;
            end
            else
            begin
                expected_level = level_expect_q.pop_front();
                if (level_bus.rms_milli !== expected_level)
                begin
                    $error("rms_milli: expected %0d, actual %0d",
                           expected_level, level_bus.rms_milli);
                    mismatches++;
                end
            end
        end
    end

    // A hung handshake on either side ends the run as a failure.
    always @(posedge clk)
    begin
        if ((row_bus.valid && row_bus.ready) || (level_bus.valid && level_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        row_bus.valid      = 1'b0;
        row_bus.sample_ch0 = '0;
        row_bus.sample_ch1 = '0;
        row_bus.sample_ch2 = '0;
        row_bus.sample_ch3 = '0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_CHANNEL_SELECT;
        cfg_data           = '0;
        reset_meter_model();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_skip_and_window();
        test_register_change();
        test_register_extremes();
        test_random_traffic();

        // Every owed level has to arrive before the verdict.
        settle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
